### rtl/br4mul_pkg.sv
package br4mul_pkg;

    localparam int OpW       = 32;
    localparam int PpW       = OpW + 1;
    localparam int ProdW     = 2 * OpW;
    localparam int NumDigits = OpW / 2 + 1;
    localparam int PadW      = 2 * NumDigits + 1;

    typedef logic [ProdW-1:0] t_row;
    typedef t_row t_rows [NumDigits];

    // sign-magnitude Booth digit: bit 2 sign, bits 1:0 magnitude
    typedef logic [2:0] t_booth;

    localparam t_booth BoothZero = 3'b000;
    localparam t_booth BoothPos1 = 3'b001;
    localparam t_booth BoothPos2 = 3'b010;
    localparam t_booth BoothNeg1 = 3'b101;
    localparam t_booth BoothNeg2 = 3'b110;

    localparam logic [1:0] MagOne = 2'b01;
    localparam logic [1:0] MagTwo = 2'b10;

    function automatic t_booth booth_code(input logic [2:0] slice);
        t_booth code;
        case (slice)
            3'b100:          code = BoothNeg2;
            3'b101, 3'b110:  code = BoothNeg1;
            3'b001, 3'b010:  code = BoothPos1;
            3'b011:          code = BoothPos2;
            default:         code = BoothZero;
        endcase
        return code;
    endfunction

endpackage

### rtl/br4mul_ppgen.sv
module br4mul_ppgen (
    input  logic [br4mul_pkg::OpW-1:0] i_multiplier,
    input  logic [br4mul_pkg::OpW-1:0] i_multiplicand,
    output br4mul_pkg::t_rows          o_rows
);
    import br4mul_pkg::*;

    logic [PadW-1:0]      padded;
    logic [NumDigits-2:0] neg_v;

    // one zero below, zeros above
    assign padded = {(PadW - OpW - 1)'(0), i_multiplier, 1'b0};

    for (genvar k = 0; k < NumDigits; k++) begin : g_row
        localparam int PosPrev = (k == 0) ? 0 : 2 * k - 2;
        localparam bit HasLow  = (2 * k + PpW) < ProdW;
        localparam bit HasHigh = (2 * k + PpW + 1) < ProdW;
        localparam int PosLow  = HasLow ? 2 * k + PpW : 0;
        localparam int PosHigh = HasHigh ? 2 * k + PpW + 1 : 0;

        t_booth         code;
        logic [PpW-1:0] pp;
        t_row           row;

        assign code = booth_code(padded[2*k +: 3]);

        // the top digit's sign has no row above it to correct
        if (k < NumDigits - 1) begin : g_neg
            assign neg_v[k] = code[2];
        end

        always_comb begin
            case (code[1:0])
                MagTwo:  pp = {i_multiplicand, 1'b0};
                MagOne:  pp = {1'b0, i_multiplicand};
                default: pp = '0;
            endcase
            if (code[2]) begin
                pp = ~pp;
            end

            row = ProdW'(pp) << (2 * k);
            if (k == 0) begin
                row[PpW]     = code[2];
                row[PpW + 1] = code[2];
                row[PpW + 2] = ~code[2];
            end else begin
                // +1 correction of the row below
                row[PosPrev] = neg_v[PosPrev / 2];
                if (HasLow) begin
                    row[PosLow] = ~code[2];
                end
                if (HasHigh) begin
                    row[PosHigh] = 1'b1;
                end
            end
        end

        assign o_rows[k] = row;
    end

endmodule

### rtl/br4mul_tree.sv
module br4mul_tree (
    input  br4mul_pkg::t_rows            i_rows,
    output logic [br4mul_pkg::ProdW-1:0] o_sum
);
    import br4mul_pkg::*;

    typedef struct packed {
        t_row s;
        t_row c;
    } t_sc;

    function automatic t_sc cmp42(input t_row a, input t_row b, input t_row c,
                                  input t_row d);
        t_row t;
        t_row x;
        t_sc  r;
        t   = ((b & c) | (b & d) | (c & d)) << 1;
        x   = a ^ b ^ c ^ d;
        r.s = x ^ t;
        r.c = ((a & ~x) | (t & x)) << 1;
        return r;
    endfunction

    function automatic t_sc cmp32(input t_row a, input t_row b, input t_row c);
        t_sc r;
        r.s = a ^ b ^ c;
        r.c = ((a & b) | (a & c) | (b & c)) << 1;
        return r;
    endfunction

    t_sc l1 [4];
    t_sc l2 [2];
    t_sc l3;
    t_sc l4;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l1[i] = cmp42(i_rows[4*i], i_rows[4*i+1], i_rows[4*i+2], i_rows[4*i+3]);
        end
        for (int i = 0; i < 2; i++) begin
            l2[i] = cmp42(l1[2*i].s, l1[2*i].c, l1[2*i+1].s, l1[2*i+1].c);
        end
        l3 = cmp42(l2[0].s, l2[0].c, l2[1].s, l2[1].c);
        l4 = cmp32(l3.s, l3.c, i_rows[NumDigits-1]);
    end

    // final carry-propagate add, wraps modulo 2^64
    assign o_sum = l4.s + l4.c;

endmodule

### rtl/booth_radix4_multiplier_32x32_top.sv
// Radix-4 Booth multiplier, 32 x 32 -> 64 bits, unsigned.
//
// Request channel: drive i_multiplier and i_multiplicand with start high;
// the request is taken at a rising edge where start is high and busy is low.
// busy stays low, so a request may be issued in every cycle.
//
// Result channel: o_product is valid for exactly one cycle while o_done is
// high. The receiver cannot hold results off; each o_done pulse must be
// taken when it appears.
//
// Operands are registered on acceptance; Booth partial products and the
// 4:2 compressor tree plus final adder sit between the operand register
// and the product register. Throughput is one request per cycle, one
// result per request, in request order.
//
// Reset (i_rst_n, synchronous, active low) clears the valid flags; any
// request in flight is dropped and no o_done pulse follows it.
module booth_radix4_multiplier_32x32_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [br4mul_pkg::OpW-1:0]    i_multiplier,
    input  logic [br4mul_pkg::OpW-1:0]    i_multiplicand,
    output logic                          o_done,
    output logic [br4mul_pkg::ProdW-1:0]  o_product
);
    import br4mul_pkg::*;

    logic             r_in_valid;
    logic [OpW-1:0]   r_multiplier;
    logic [OpW-1:0]   r_multiplicand;
    logic             r_done;
    logic [ProdW-1:0] r_product;
    logic [ProdW-1:0] n_product;
    logic             accept;
    t_rows            rows;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_in_valid <= accept;
            r_done     <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_multiplier   <= i_multiplier;
            r_multiplicand <= i_multiplicand;
        end
        if (r_in_valid) begin
            r_product <= n_product;
        end
    end

    br4mul_ppgen u_ppgen (
        .i_multiplier   (r_multiplier),
        .i_multiplicand (r_multiplicand),
        .o_rows         (rows)
    );

    br4mul_tree u_tree (
        .i_rows (rows),
        .o_sum  (n_product)
    );

    assign o_done    = r_done;
    assign o_product = r_product;

    a_done_follows_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2 o_done)
        else $error("request did not produce a result two cycles later");

    a_product_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##2
            (o_product == ProdW'($past(i_multiplier, 2)) * ProdW'($past(i_multiplicand, 2))))
        else $error("Booth tree product mismatch");

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

endmodule

### verif/testbench.sv
class product_board;
    logic [63:0] expected_products [$];
    int unsigned errors;

    function new();
        errors = 0;
    endfunction

    // 4:2 compressor on whole 64-bit rows; carries leave at the next weight
    static function void compress42(input logic [63:0] a, input logic [63:0] b,
                                    input logic [63:0] c, input logic [63:0] d,
                                    output logic [63:0] sum, output logic [63:0] cy);
        logic [63:0] t;
        logic [63:0] x;
        t   = ((b & c) | (b & d) | (c & d)) << 1;
        x   = a ^ b ^ c ^ d;
        sum = x ^ t;
        cy  = ((a & ~x) | (t & x)) << 1;
    endfunction

    static function logic [63:0] booth_product(input logic [31:0] mplier,
                                               input logic [31:0] mcand);
        logic [34:0]        padded;
        logic [63:0]        rows [17];
        logic [63:0]        lvl1 [8];
        logic [63:0]        lvl2 [4];
        logic [63:0]        s3, c3, s4, c4;
        br4mul_pkg::t_booth digit;
        logic [32:0]        pp;
        logic               neg, prev_neg;
        padded   = {2'b00, mplier, 1'b0};
        prev_neg = 1'b0;
        for (int k = 0; k < 17; k++) begin
            case (padded[2*k +: 3])
                3'b100:         digit = br4mul_pkg::BoothNeg2;
                3'b101, 3'b110: digit = br4mul_pkg::BoothNeg1;
                3'b001, 3'b010: digit = br4mul_pkg::BoothPos1;
                3'b011:         digit = br4mul_pkg::BoothPos2;
                default:        digit = br4mul_pkg::BoothZero;
            endcase
            neg = digit[2];
            case (digit[1:0])
                br4mul_pkg::MagTwo: pp = {mcand, 1'b0};
                br4mul_pkg::MagOne: pp = {1'b0, mcand};
                default:            pp = '0;
            endcase
            if (neg) pp = ~pp;
            rows[k] = 64'(pp) << (2 * k);
            if (k == 0) begin
                rows[k][33] = neg;
                rows[k][34] = neg;
                rows[k][35] = !neg;
            end else begin
                // +1 of the row below completes its two's complement
                rows[k][2*k-2] = prev_neg;
                if (2 * k + 33 < 64) rows[k][2*k+33] = !neg;
                if (2 * k + 34 < 64) rows[k][2*k+34] = 1'b1;
            end
            prev_neg = neg;
        end
        for (int k = 0; k < 4; k++)
            compress42(rows[4*k], rows[4*k+1], rows[4*k+2], rows[4*k+3],
                       lvl1[2*k], lvl1[2*k+1]);
        for (int k = 0; k < 2; k++)
            compress42(lvl1[4*k], lvl1[4*k+1], lvl1[4*k+2], lvl1[4*k+3],
                       lvl2[2*k], lvl2[2*k+1]);
        compress42(lvl2[0], lvl2[1], lvl2[2], lvl2[3], s3, c3);
        s4 = s3 ^ c3 ^ rows[16];
        c4 = ((s3 & c3) | (s3 & rows[16]) | (c3 & rows[16])) << 1;
        return s4 + c4;
    endfunction

    function void note_request(input logic [31:0] mplier, input logic [31:0] mcand);
        expected_products.push_back(booth_product(mplier, mcand));
    endfunction

    function void check_product(input logic [63:0] actual);
        logic [63:0] want;
        if (expected_products.size() == 0) begin
            $error("product: none expected, actual %h", actual);
            errors++;
            return;
        end
        want = expected_products.pop_front();
        if (actual !== want) begin
            $error("product: expected %h, actual %h", want, actual);
            errors++;
        end
    endfunction

    function int pending();
        return expected_products.size();
    endfunction
endclass

module testbench;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic [br4mul_pkg::OpW-1:0]         i_multiplier = '0;
    logic [br4mul_pkg::OpW-1:0]         i_multiplicand = '0;
    logic                               o_done;
    logic [br4mul_pkg::ProdW-1:0]       o_product;

    product_board board;
    bit           steady_stream = 1'b0;

    booth_radix4_multiplier_32x32_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_multiplier   (i_multiplier),
        .i_multiplicand (i_multiplicand),
        .o_done         (o_done),
        .o_product      (o_product)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_product(o_product);
    end

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_request(input logic [31:0] mplier, input logic [31:0] mcand);
        if (!steady_stream && $urandom_range(0, 99) < 27) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_multiplier   <= mplier;
        i_multiplicand <= mcand;
        do @(posedge i_clk); while (busy);
        board.note_request(mplier, mcand);
    endtask

    // full-range values in four picks of ten; the rest are edges, one-hot, one-cold and near-edge values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return ~(32'h1 << $urandom_range(0, 31));
            4:       return 32'($urandom_range(0, 255));
            5:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0001, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0001);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h8000_0001);
        // digit sweeps: repeating patterns that exercise +1, -1, +2, -2 across the digit positions
        send_request(32'h5555_5555, 32'hDEAD_BEEF);
        send_request(32'hAAAA_AAAA, 32'hFFFF_FFFF);
        send_request(32'h3333_3333, 32'h8000_0000);
        send_request(32'hCCCC_CCCC, 32'hC000_0001);
        send_request(32'h9999_9999, 32'h1234_5678);
        send_request(32'h6666_6666, 32'hFEDC_BA98);
        send_request(32'h8888_8888, 32'hFFFF_FFFE);
        send_request(32'h7777_7777, 32'h0000_0002);
        send_request(32'hC000_0000, 32'h7FFF_FFFF);
        send_request(32'h0000_0003, 32'hAAAA_AAAA);
        send_request(32'h0000_0002, 32'h5555_5555);
        send_request(32'hFFFF_0000, 32'h0000_FFFF);

        for (int n = 0; n < 550; n++) begin
            steady_stream = (n >= 200 && n < 320);
            send_request(pick_operand(), pick_operand());
        end
        start <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
